@@ sv/bsi_pkg.sv @@
package bsi_pkg;

    // Operation selector carried beside each input item.
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_INSERT = 3'd0;
    localparam mode_t MODE_ERASE  = 3'd1;
    localparam mode_t MODE_CHECK  = 3'd2;
    localparam mode_t MODE_FIND   = 3'd3;
    localparam mode_t MODE_CLEAR  = 3'd4;
    localparam mode_t MODE_OR     = 3'd5;
    localparam mode_t MODE_AND    = 3'd6;
    localparam mode_t MODE_XOR    = 3'd7;

    // Fixed field widths of the item payloads.
    localparam int POS_W   = 12;
    localparam int WIDX_W  = 6;
    localparam int WVAL_W  = 64;
    localparam int CNT_W   = 13;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 32;

    // Population of one byte; the counter walks a word a byte at a time.
    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

@@ sv/bitmap_set_index.sv @@
// Membership bitmap of WORD_COUNT words of WORD_BITS bits, held in a single-port memory with a
// registered read, and worked by one small sequencer. One item is taken at a time; s_tready is
// high only while the sequencer is idle, and a finished result waits in the output register so
// the next item may be taken meanwhile. Insert, erase and check first split the position into
// word and bit by a multiplication with the reciprocal of WORD_BITS, then read the word, modify
// it and (but for check) write it back, and update the population by walking old and new word
// a byte a cycle. Or, and and xor merges skip the split. Find next reads one word after another
// from the word of the position on, and stops at the first set bit or after the last word.
// Clear all sweeps the memory one word a cycle. A position beyond the capacity, or a word index
// beyond the store, is answered without touching the memory. While the output register still
// holds an earlier result that is not taken, the finished item waits in the sequencer. After
// reset the same sweep clears the memory, so the block accepts no item until the sweep ends.
module bitmap_set_index #(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // position [11:0], word_index [17:12], word_value [81:18], zero [87:82]
    input  logic [bsi_pkg::IN_W-1:0]  s_tdata,
    // mode [2:0]
    input  bsi_pkg::mode_t            s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // is_member [0], next_position [13:1], found [14], population [27:15], zero [31:28]
    output logic [bsi_pkg::OUT_W-1:0] m_tdata
);
    import bsi_pkg::*;

    localparam int CAP = WORD_COUNT * WORD_BITS;
    localparam int AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int RW  = $clog2(WORD_BITS);
    localparam int PW  = $clog2(CAP + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

    // Reciprocal of WORD_BITS, exact for every 12-bit position.
    localparam int MUL_W  = POS_W + 1;
    localparam int PROD_W = POS_W + MUL_W;
    localparam int DIV_SH = POS_W + RW;
    localparam logic [MUL_W-1:0] RECIP  = MUL_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);
    localparam logic [POS_W-1:0] WB_POS = POS_W'(WORD_BITS);

    // Sequencer states.
    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_SRD  = 4'd3;
    localparam logic [3:0] ST_SISO = 4'd4;
    localparam logic [3:0] ST_SENC = 4'd5;
    localparam logic [3:0] ST_MRD  = 4'd6;
    localparam logic [3:0] ST_MOD  = 4'd7;
    localparam logic [3:0] ST_CNT  = 4'd8;
    localparam logic [3:0] ST_CLR  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;
    localparam logic [3:0] ST_REM  = 4'd11;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [3:0]           state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] wval_reg, wval_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [3:0]           step_reg, step_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [PW-1:0]        base_reg, base_next;
    logic                 first_reg, first_next;
    logic [WORD_BITS-1:0] onehot_reg, onehot_next;
    logic                 nz_reg, nz_next;
    logic [63:0]          old_word_reg, old_word_next;
    logic [63:0]          new_word_reg, new_word_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 member_reg, member_next;
    logic [CNT_W-1:0]     npos_reg, npos_next;
    logic                 found_reg, found_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 pos_ok;
    logic [PROD_W-1:0]    prod;
    logic [POS_W-1:0]     quo_w;
    logic [POS_W-1:0]     word_base;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] mod_word;
    logic [RW-1:0]        hit_idx;
    logic                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Range check on the held item.
    assign pos_ok   = (32'(pos_reg) < CAP);
    assign out_free = !m_tvalid_reg || m_tready;

    // Word number from the position, then the first position of that word.
    assign prod      = PROD_W'(pos_reg) * PROD_W'(RECIP);
    assign quo_w     = POS_W'(prod >> DIV_SH);
    assign word_base = quo_reg * WB_POS;

    // Single-bit mask for insert, erase and check.
    assign bit_mask = WORD_BITS'(1) << rem_reg;

    // Scan word with the bits below the start masked off on the first word.
    assign masked = first_reg ? (rd_data_reg & ({WORD_BITS{1'b1}} << rem_reg)) : rd_data_reg;

    // Modified word for a read-modify-write.
    always_comb
    begin
        unique case (mode_reg)
            MODE_INSERT: mod_word = rd_data_reg | bit_mask;
            MODE_ERASE:  mod_word = rd_data_reg & ~bit_mask;
            MODE_OR:     mod_word = rd_data_reg | wval_reg;
            MODE_AND:    mod_word = rd_data_reg & wval_reg;
            MODE_XOR:    mod_word = rd_data_reg ^ wval_reg;
            default:     mod_word = rd_data_reg;
        endcase
    end

    // Encode the isolated lowest set bit into its index.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (onehot_reg[i])
            begin
                hit_idx = hit_idx | RW'(i);
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        wval_next     = wval_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        addr_next     = addr_reg;
        base_next     = base_reg;
        first_next    = first_reg;
        onehot_next   = onehot_reg;
        nz_next       = nz_reg;
        old_word_next = old_word_reg;
        new_word_next = new_word_reg;
        count_next    = count_reg;
        member_next   = member_reg;
        npos_next     = npos_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_data       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next   = s_tuser;
                    pos_next    = s_tdata[POS_W-1:0];
                    wval_next   = s_tdata[POS_W+WIDX_W+WORD_BITS-1:POS_W+WIDX_W];
                    quo_next    = s_tdata[POS_W-1:0];
                    rem_next    = '0;
                    step_next   = '0;
                    member_next = 1'b0;
                    npos_next   = '0;
                    found_next  = 1'b0;
                    priority case (s_tuser)
                        MODE_CLEAR:
                        begin
                            addr_next  = '0;
                            count_next = '0;
                            state_next = ST_CLR;
                        end
                        MODE_OR, MODE_AND, MODE_XOR:
                        begin
                            if (32'(s_tdata[POS_W+WIDX_W-1:POS_W]) < WORD_COUNT)
                            begin
                                addr_next = AW'(s_tdata[POS_W+WIDX_W-1:POS_W]);
                                state_next = ST_MRD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DIV;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                quo_next   = quo_w;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                rem_next = RW'(pos_reg - word_base);
                if (!pos_ok)
                begin
                    if (mode_reg == MODE_FIND)
                    begin
                        npos_next = CNT_W'(CAP);
                    end
                    state_next = ST_DONE;
                end
                else if (mode_reg == MODE_FIND)
                begin
                    addr_next  = quo_reg[AW-1:0];
                    base_next  = PW'(word_base);
                    first_next = 1'b1;
                    state_next = ST_SRD;
                end
                else
                begin
                    addr_next  = quo_reg[AW-1:0];
                    state_next = ST_MRD;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SISO;
            end
            ST_SISO:
            begin
                onehot_next = masked & (~masked + WORD_BITS'(1));
                nz_next     = |masked;
                state_next  = ST_SENC;
            end
            ST_SENC:
            begin
                if (nz_reg)
                begin
                    npos_next  = CNT_W'(base_reg + PW'(hit_idx));
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    npos_next  = CNT_W'(CAP);
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next  = addr_reg + AW'(1);
                    base_next  = base_reg + PW'(WORD_BITS);
                    first_next = 1'b0;
                    state_next = ST_SRD;
                end
            end
            ST_MRD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                wr_en         = (mode_reg != MODE_CHECK);
                wr_data       = mod_word;
                member_next   = (mode_reg == MODE_CHECK) && ((rd_data_reg & bit_mask) != '0);
                old_word_next = 64'(rd_data_reg);
                new_word_next = 64'(mod_word);
                step_next     = '0;
                state_next    = ST_CNT;
            end
            ST_CNT:
            begin
                count_next = count_reg + CNT_W'(popcnt8(new_word_reg[7:0]))
                                       - CNT_W'(popcnt8(old_word_reg[7:0]));
                old_word_next = {8'h00, old_word_reg[63:8]};
                new_word_next = {8'h00, new_word_reg[63:8]};
                step_next     = step_reg + 4'd1;
                if (step_reg == 4'd7)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, count_reg, found_reg, npos_reg, member_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Word store: one write and one registered read a cycle, both at addr_reg.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            addr_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        pos_reg      <= pos_next;
        wval_reg     <= wval_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        base_reg     <= base_next;
        first_reg    <= first_next;
        onehot_reg   <= onehot_next;
        nz_reg       <= nz_next;
        old_word_reg <= old_word_next;
        new_word_reg <= new_word_next;
        member_reg   <= member_next;
        npos_reg     <= npos_next;
        found_reg    <= found_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule
